>>> rtl/core/smss_pkg.sv
// Shared constants, control types and the sequencer program of the staircase search.
package smss_pkg;

	localparam int CNT_W  = 5;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 32;

	// program steps
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_HIT  = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	// jump conditions
	localparam logic [1:0] COND_NONE  = 2'd0;
	localparam logic [1:0] COND_START = 2'd1;
	localparam logic [1:0] COND_WALK  = 2'd2;
	localparam logic [1:0] COND_EMIT  = 2'd3;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic take_in;
		logic walk;
		logic emit;
		logic hit;
	} ctrl_t;

	typedef struct packed {
		ctrl_t      ctrl;
		logic [1:0] cond;
		logic [1:0] next;
		logic [1:0] jmp_a;
		logic [1:0] jmp_b;
	} uword_t;

	typedef struct packed {
		logic start;
		logic start_ok;
		logic hit;
		logic stop;
		logic out_free;
	} stat_t;

	function automatic uword_t ucode(input logic [1:0] step);
		uword_t w;
		w = '0;
		unique case (step)
			ST_IDLE: begin
				w.ctrl = '{take_in: 1'b1, walk: 1'b0, emit: 1'b0, hit: 1'b0};
				w.cond = COND_START; w.next = ST_IDLE; w.jmp_a = ST_WALK; w.jmp_b = ST_MISS;
			end
			ST_WALK: begin
				w.ctrl = '{take_in: 1'b0, walk: 1'b1, emit: 1'b0, hit: 1'b0};
				w.cond = COND_WALK; w.next = ST_WALK; w.jmp_a = ST_HIT; w.jmp_b = ST_MISS;
			end
			ST_HIT: begin
				w.ctrl = '{take_in: 1'b0, walk: 1'b0, emit: 1'b1, hit: 1'b1};
				w.cond = COND_EMIT; w.next = ST_HIT; w.jmp_a = ST_IDLE; w.jmp_b = ST_IDLE;
			end
			ST_MISS: begin
				w.ctrl = '{take_in: 1'b0, walk: 1'b0, emit: 1'b1, hit: 1'b0};
				w.cond = COND_EMIT; w.next = ST_MISS; w.jmp_a = ST_IDLE; w.jmp_b = ST_IDLE;
			end
			default: begin
				w.ctrl = '{take_in: 1'b0, walk: 1'b0, emit: 1'b0, hit: 1'b0};
				w.cond = COND_NONE; w.next = ST_IDLE; w.jmp_a = ST_IDLE; w.jmp_b = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/smss_in_if.sv
// Input channel: valid/ready with one load or search command.
interface smss_in_if;
	import smss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         column_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] search_key;

	modport source (output valid, command, row_index, column_index, entry_value, search_key,
		input ready);
	modport sink (input valid, command, row_index, column_index, entry_value, search_key,
		output ready);
endinterface

>>> rtl/core/smss_out_if.sv
// Output channel: valid/ready with the search answer.
interface smss_out_if;
	logic valid;
	logic ready;
	logic found;

	modport source (output valid, found, input ready);
	modport sink (input valid, found, output ready);
endinterface

>>> rtl/core/sorted_matrix_staircase_search_top.sv
// Staircase search over a row- and column-sorted matrix held in an internal memory.
// Load beat: the entry is written at the edge that accepts it; no result.
// Search beat: the walk visits at most rows + columns - 1 entries (none if a count is zero),
// then the result register loads once the output is free; the memory read port sets one entry per cycle.
// Input ready returns once the result is registered; a waiting result does not block loads.
// Reset clears the sequencer, the counts and the output valid; matrix entries stay unknown.
module sorted_matrix_staircase_search_top #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLUMNS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	smss_in_if.sink           in_ch,
	smss_out_if.source        out_ch
);
	import smss_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_ROWS * (2 ** CW);

	logic [CNT_W-1:0] row_count_q;
	logic [CNT_W-1:0] column_count_q;
	logic [CNT_W-1:0] rows_c;
	logic [CNT_W-1:0] cols_c;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]         r_q;
	logic [CNT_W-1:0]         c_q;
	logic [CNT_W-1:0]         r_n;
	logic [CNT_W-1:0]         c_n;
	logic [CNT_W-1:0]         row_rd;
	logic [CNT_W-1:0]         col_rd;
	logic [31:0]              row_rd_x;
	logic [31:0]              col_rd_x;
	logic [31:0]              row_wr_x;
	logic [31:0]              col_wr_x;
	logic [AW-1:0]            raddr;
	logic [AW-1:0]            waddr;
	logic                     we;
	logic                     accept;
	logic                     out_valid_q;
	logic                     found_q;
	logic                     cfg_wr;

	stat_t stat;
	ctrl_t ctrl;

	smss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= '0;
			column_count_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROWS)
				row_count_q <= pwdata[CNT_W-1:0];
			else
				column_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_ROWS)
			prdata = {{(32-CNT_W){1'b0}}, row_count_q};
		else
			prdata = {{(32-CNT_W){1'b0}}, column_count_q};
	end

	// saturate counts to the array size
	assign rows_c = (32'(row_count_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_q;
	assign cols_c = (32'(column_count_q) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : column_count_q;

	assign in_ch.ready = ctrl.take_in;
	assign accept      = in_ch.valid && in_ch.ready;

	// walk step: compare the entry read last cycle and pick the next position
	always_comb begin
		r_n = r_q;
		c_n = c_q;
		if (rdata_q > key_q)
			c_n = c_q - 1'b1;
		else
			r_n = r_q + 1'b1;
	end

	always_comb begin
		stat.start    = accept && (in_ch.command == CMD_SEARCH);
		stat.start_ok = (rows_c != '0) && (cols_c != '0);
		stat.hit      = (rdata_q == key_q);
		stat.stop     = !((r_n < rows_c) && (c_n != '0));
		stat.out_free = !out_valid_q || out_ch.ready;
	end

	always_ff @(posedge clk) begin
		if (stat.start) begin
			key_q <= in_ch.search_key;
			r_q   <= '0;
			c_q   <= cols_c;
		end else if (ctrl.walk) begin
			r_q <= r_n;
			c_q <= c_n;
		end
	end

	// memory addressing: column pointer runs one above the column it names
	assign row_rd   = ctrl.walk ? r_n : '0;
	assign col_rd   = (ctrl.walk ? c_n : cols_c) - 1'b1;
	assign row_rd_x = 32'(row_rd);
	assign col_rd_x = 32'(col_rd);
	assign raddr    = {row_rd_x[RW-1:0], col_rd_x[CW-1:0]};

	assign row_wr_x = 32'(in_ch.row_index);
	assign col_wr_x = 32'(in_ch.column_index);
	assign waddr    = {row_wr_x[RW-1:0], col_wr_x[CW-1:0]};
	assign we       = accept && (in_ch.command == CMD_LOAD)
		&& (row_wr_x < MAX_ROWS) && (col_wr_x < MAX_COLUMNS);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= in_ch.entry_value;
		rdata_q <= mem[raddr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.emit && stat.out_free)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && stat.out_free)
			found_q <= ctrl.hit;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.found = found_q;

endmodule

>>> rtl/core/smss_seq.sv
// Step counter and program lookup with conditional jumps.
module smss_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  smss_pkg::stat_t stat,
	output smss_pkg::ctrl_t ctrl
);
	import smss_pkg::*;

	logic [1:0] step_q;
	logic [1:0] step_n;
	uword_t     uw;

	always_comb begin
		uw   = ucode(step_q);
		ctrl = uw.ctrl;
		step_n = uw.next;
		case (uw.cond)
			COND_START: begin
				if (stat.start)
					step_n = stat.start_ok ? uw.jmp_a : uw.jmp_b;
			end
			COND_WALK: begin
				if (stat.hit)
					step_n = uw.jmp_a;
				else if (stat.stop)
					step_n = uw.jmp_b;
			end
			COND_EMIT: begin
				if (stat.out_free)
					step_n = uw.jmp_a;
			end
			default: step_n = uw.next;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_IDLE;
		else
			step_q <= step_n;
	end

endmodule

>>> rtl/core/smss_chk.sv
// Port-level checks for the staircase search top, attached by bind.
module smss_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_command,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic pready
);
	import smss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_found_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_found))
		else $error("result changed while stalled");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == CMD_SEARCH) |=> !in_ready)
		else $error("input taken during a search");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == CMD_LOAD) |=> in_ready)
		else $error("load beat stalled the input");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind sorted_matrix_staircase_search_top smss_chk u_smss_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_command (in_ch.command),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_found  (out_ch.found),
	.pready     (pready)
);

>>> tb/sv/sorted_matrix_staircase_search_top_tb.sv
// Self-checking testbench for the staircase search block: loads, searches and count registers.
module sorted_matrix_staircase_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smss_pkg::*;

	localparam int MAX_ROWS      = 16;
	localparam int MAX_COLUMNS   = 16;
	localparam int ITEM_TARGET   = 1600;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int KEY_MIN       = 32'sh8000_0000;
	localparam int KEY_MAX       = 32'sh7fff_ffff;

	// Keeps its own copy of the matrix and counts, and the answers still owed.
	class staircase_scoreboard;
		int               cells [MAX_ROWS][MAX_COLUMNS];
		logic [CNT_W-1:0] rows_reg = '0;
		logic [CNT_W-1:0] cols_reg = '0;
		bit               found_due [$];
		int               errors = 0;

		function void set_count(logic which, logic [CNT_W-1:0] value);
			if (which == REG_ROWS) rows_reg = value;
			else cols_reg = value;
		endfunction

		function bit walk_finds(int key);
			int nr, nc, r, c;
			nr = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
			nc = (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
			r = 0;
			c = nc - 1;
			// start top-right; step left past larger entries, down past smaller ones
			while (r < nr && c >= 0) begin
				if (cells[r][c] == key) return 1'b1;
				if (cells[r][c] > key) c--;
				else r++;
			end
			return 1'b0;
		endfunction

		function void note_command(logic cmd, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
				int value, int key);
			if (cmd == CMD_LOAD) cells[r][c] = value;
			else found_due.push_back(walk_finds(key));
		endfunction

		function void check_found(logic got);
			bit want;
			if (found_due.size() == 0) begin
				errors++;
				$error("found: result beat with no search pending, actual %0b", got);
				return;
			end
			want = found_due.pop_front();
			if (got !== want) begin
				errors++;
				$error("found mismatch: expected %0b, actual %0b", want, got);
			end
		endfunction

		function int pending();
			return found_due.size();
		endfunction
	endclass

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	smss_in_if  in_ch ();
	smss_out_if out_ch ();

	staircase_scoreboard sb;

	int grid [MAX_ROWS][MAX_COLUMNS];
	int span_rows     = 0;
	int span_cols     = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 64;
	int beats_sent    = 0;
	int cycles        = 0;
	bit hold_req      = 1'b0;

	sorted_matrix_staircase_search_top #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLUMNS(MAX_COLUMNS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input int value, input int key);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid        = 1'b0;
			in_ch.command      = 1'($urandom);
			in_ch.row_index    = IDX_W'($urandom);
			in_ch.column_index = IDX_W'($urandom);
			in_ch.entry_value  = $urandom;
			in_ch.search_key   = $urandom;
			@(negedge clk);
		end
		in_ch.valid        = 1'b1;
		in_ch.command      = cmd;
		in_ch.row_index    = r;
		in_ch.column_index = c;
		in_ch.entry_value  = value;
		in_ch.search_key   = key;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_command(cmd, r, c, value, key);
		beats_sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic load_entry(input int r, input int c, input int value);
		grid[r][c] = value;
		send_beat(CMD_LOAD, IDX_W'(r), IDX_W'(c), value, int'($urandom));
	endtask

	task automatic search_for(input int key);
		send_beat(CMD_SEARCH, IDX_W'($urandom), IDX_W'($urandom), int'($urandom), key);
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic config_write(input logic which, input logic [CNT_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {which, 2'b00};
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_count(which, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_counts(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
		drain();
		config_write(REG_ROWS, rows);
		config_write(REG_COLS, cols);
		span_rows = (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
		span_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
	endtask

	function automatic logic [CNT_W-1:0] pick_count(input int limit);
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 8) return '0;
		if (roll < 18) return CNT_W'(limit);
		if (roll < 26) return CNT_W'($urandom_range(31, limit + 1));
		if (roll < 34) return CNT_W'($urandom_range(limit, 1));
		return CNT_W'($urandom_range(6, 1));
	endfunction

	function automatic int pick_key();
		int roll;
		int hit;
		roll = $urandom_range(99, 0);
		if (span_rows > 0 && span_cols > 0 && roll < 65) begin
			hit = grid[$urandom_range(span_rows - 1, 0)][$urandom_range(span_cols - 1, 0)];
			if (roll < 50) return hit;
			return (roll < 58) ? hit + 1 : hit - 1;
		end
		if (roll < 72) return KEY_MIN;
		if (roll < 79) return KEY_MAX;
		return int'($urandom);
	endfunction

	// Write a fresh ascending block at the top-left corner, row by row.
	task automatic refill(input int nr, input int nc, input longint start);
		longint step_top, v;
		case ($urandom_range(3, 0))
			0: step_top = 2;
			1: step_top = 1000;
			2: step_top = 1 << 20;
			default: step_top = 1 << 27;
		endcase
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				if (r == 0 && c == 0) begin
					v = start;
				end else begin
					v = KEY_MIN;
					if (r > 0) v = grid[r-1][c];
					if (c > 0 && grid[r][c-1] > v) v = grid[r][c-1];
					v += $urandom_range(step_top, 0);
				end
				if (v > KEY_MAX) v = KEY_MAX;
				load_entry(r, c, int'(v));
			end
		end
	endtask

	// Mostly keep the region sorted; now and then drop an arbitrary value anywhere.
	task automatic random_load();
		int r, c;
		longint lo, hi;
		longint unsigned span;
		if (span_rows == 0 || span_cols == 0 || $urandom_range(3, 0) == 0) begin
			load_entry($urandom_range(MAX_ROWS - 1, 0), $urandom_range(MAX_COLUMNS - 1, 0),
				int'($urandom));
			return;
		end
		r  = $urandom_range(span_rows - 1, 0);
		c  = $urandom_range(span_cols - 1, 0);
		lo = KEY_MIN;
		hi = KEY_MAX;
		if (r > 0 && grid[r-1][c] > lo) lo = grid[r-1][c];
		if (c > 0 && grid[r][c-1] > lo) lo = grid[r][c-1];
		if (r < span_rows - 1 && grid[r+1][c] < hi) hi = grid[r+1][c];
		if (c < span_cols - 1 && grid[r][c+1] < hi) hi = grid[r][c+1];
		if (hi < lo) hi = lo;
		span = hi - lo + 1;
		load_entry(r, c, int'(lo + longint'({$urandom, $urandom} % span)));
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left     = 0;
		out_ch.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else begin
				out_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_found(out_ch.found);
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** sorted_matrix_staircase_search_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int n;
		bit first;
		sb                 = new;
		in_ch.valid        = 1'b0;
		in_ch.command      = CMD_LOAD;
		in_ch.row_index    = '0;
		in_ch.column_index = '0;
		in_ch.entry_value  = '0;
		in_ch.search_key   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero counts out of reset and with either count zero: no entry is visited
		search_for(0);
		set_counts(1, 0);
		search_for(KEY_MIN);
		set_counts(0, 1);
		search_for(KEY_MAX);

		load_entry(0, 0, KEY_MIN);
		load_entry(0, 1, 100);
		load_entry(1, 0, -7);
		load_entry(1, 1, KEY_MAX);
		set_counts(1, 2);
		search_for(KEY_MIN);
		search_for(100);
		search_for(0);
		set_counts(2, 2);
		search_for(KEY_MAX);
		search_for(-7);
		search_for(KEY_MAX - 1);

		// fill the whole store so any later region reads written entries only
		refill(MAX_ROWS, MAX_COLUMNS, KEY_MIN);
		load_entry(MAX_ROWS - 1, MAX_COLUMNS - 1, KEY_MAX);
		set_counts(31, 31);
		search_for(KEY_MIN);
		search_for(KEY_MAX);
		search_for(grid[7][9]);

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 64 : 0;
			recv_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 25 : 0;
			first = 1'b1;
			while (beats_sent < ITEM_TARGET * (mode + 1) / 3) begin
				set_counts(pick_count(MAX_ROWS), pick_count(MAX_COLUMNS));
				if (span_rows > 0 && span_cols > 0 && $urandom_range(2, 0) == 0)
					refill(span_rows, span_cols, ($urandom_range(3, 0) == 0) ? longint'(KEY_MIN) :
						longint'($urandom_range(32'h7fff_ffff, 0)) - (64'sd1 << 30));
				// block the result path for a long stretch while beats keep coming
				if (mode == 2 && first) hold_req = 1'b1;
				n = $urandom_range(70, 30);
				for (int i = 0; i < n; i++) begin
					if (mode == 1 && first && i == n / 2) drain();
					if ($urandom_range(99, 0) < 20) random_load();
					else search_for(pick_key());
				end
				first = 1'b0;
			end
		end

		drain();
		if (sb.errors == 0)
			$display("** sorted_matrix_staircase_search_top: PASSED **");
		else
			$display("** sorted_matrix_staircase_search_top: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/smss_pkg.sv
rtl/core/smss_in_if.sv
rtl/core/smss_out_if.sv
rtl/core/smss_seq.sv
rtl/core/sorted_matrix_staircase_search_top.sv
rtl/core/smss_chk.sv
tb/sv/sorted_matrix_staircase_search_top_tb.sv
